// ===== rtl/rebd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebd_pkg
// Shared types, codes and the quadrature transition table for the rotary
// encoder and button decoder.
// ----------------------------------------------------------------------------
package rebd_pkg;

    localparam int CFG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_LONG_PRESS   = 2'd1,
        CFG_DOUBLE_CLICK = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_TRIPLE = 3'd3,
        EV_LONG   = 3'd4
    } t_btn_event;

    localparam logic [1:0] QUAD_DETENT = 2'b11;

    typedef logic signed [1:0]       t_step;
    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        t_step      step;
        t_pos       position;
        t_btn_event button_event;
        logic       held_now;
    } t_result;

    // direction for a transition from prev to curr line pair
    function automatic t_step quad_dir(input logic [1:0] prev, input logic [1:0] curr);
        t_step d;
        case ({prev, curr})
            4'b0001: d = -2'sd1;
            4'b0010: d =  2'sd1;
            4'b0100: d =  2'sd1;
            4'b0111: d = -2'sd1;
            4'b1000: d = -2'sd1;
            4'b1011: d =  2'sd1;
            4'b1101: d =  2'sd1;
            4'b1110: d = -2'sd1;
            default: d =  2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/rebd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebd_in_if / rebd_out_if
// Valid/ready channels for encoder samples and decoded result beats.
// ----------------------------------------------------------------------------
interface rebd_in_if;
    logic valid;
    logic ready;
    logic line_a;
    logic line_b;
    logic button_line;
    logic ms_tick;

    modport source (output valid, output line_a, output line_b, output button_line,
                    output ms_tick, input ready);
    modport sink   (input valid, input line_a, input line_b, input button_line,
                    input ms_tick, output ready);
endinterface

interface rebd_out_if;
    import rebd_pkg::*;

    logic       valid;
    logic       ready;
    t_step      step;
    t_pos       position;
    logic [2:0] button_event;
    logic       held_now;

    modport source (output valid, output step, output position, output button_event,
                    output held_now, input ready);
    modport sink   (input valid, input step, input position, input button_event,
                    input held_now, output ready);
endinterface

// ===== rtl/rotary_encoder_button_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder_top
// Quadrature decoder with detent stepping, plus a debounced push button with
// long press and single/double/triple click gestures.
//
// Channel   Dir  Beat contents
// i_in      in   line_a, line_b, button_line, ms_tick
// o_out     out  step, position, button_event, held_now
// i_cfg_*   in   register index, 16-bit value
//
// One sample is accepted per cycle while ready is high.
// All decode work is a single pass from the state registers into the result
// register. A skid register keeps i_in.ready high for one stalled beat; ready
// drops only while both output and skid registers are full, and during reset.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rebd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rebd_pkg::CFG_W-1:0]     i_cfg_data,
    rebd_in_if.sink                        i_in,
    rebd_out_if.source                     o_out
);
    import rebd_pkg::*;

    logic [CFG_W-1:0]  r_debounce_lim;
    logic [CFG_W-1:0]  r_long_lim;
    logic [CFG_W-1:0]  r_quiet_lim;

    logic [1:0]        r_quad_state, n_quad_state;
    logic signed [3:0] r_sub_count,  n_sub_count;
    t_pos              r_position,   n_position;
    logic [TIME_W-1:0] r_time_ms,    n_time_ms;
    logic [TIME_W-1:0] r_press_stamp,    n_press_stamp;
    logic [TIME_W-1:0] r_release_stamp,  n_release_stamp;
    logic [TIME_W-1:0] r_accepted_stamp, n_accepted_stamp;
    logic              r_button_held, n_button_held;
    logic              r_long_fired,  n_long_fired;
    logic [1:0]        r_click_tally, n_click_tally;

    t_result           r_out, r_skid, n_result;
    logic              r_out_v, r_skid_v;

    logic              in_fire, out_fire, pressed;
    logic [1:0]        cur_lines;
    t_step             dir, step_v;
    logic signed [4:0] sub_sum;
    logic signed [3:0] sub_sat;
    t_btn_event        event_v;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_fire = r_out_v & o_out.ready;
    assign i_in.ready = i_rst_n & ~r_skid_v;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_lim <= CFG_W'(5);
            r_long_lim     <= CFG_W'(800);
            r_quiet_lim    <= CFG_W'(300);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:     r_debounce_lim <= i_cfg_data;
                CFG_LONG_PRESS:   r_long_lim     <= i_cfg_data;
                CFG_DOUBLE_CLICK: r_quiet_lim    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode one sample
    always_comb begin
        pressed   = ~i_in.button_line;
        n_time_ms = r_time_ms + TIME_W'(i_in.ms_tick);

        cur_lines    = {i_in.line_a, i_in.line_b};
        dir          = quad_dir(r_quad_state, cur_lines);
        n_quad_state = cur_lines;
        sub_sum      = 5'(r_sub_count) + 5'(dir);
        if (sub_sum > 5'sd7) begin
            sub_sat = 4'sd7;
        end else if (sub_sum < -5'sd8) begin
            sub_sat = -4'sd8;
        end else begin
            sub_sat = sub_sum[3:0];
        end
        step_v      = 2'sd0;
        n_sub_count = r_sub_count;
        if (dir != 2'sd0) begin
            n_sub_count = sub_sat;
            if (cur_lines == QUAD_DETENT) begin
                if (sub_sat >= 4'sd2) begin
                    step_v = 2'sd1;
                end else if (sub_sat <= -4'sd2) begin
                    step_v = -2'sd1;
                end
                n_sub_count = 4'sd0;
            end
        end
        n_position = r_position + POS_W'(step_v);

        n_button_held    = r_button_held;
        n_press_stamp    = r_press_stamp;
        n_release_stamp  = r_release_stamp;
        n_accepted_stamp = r_accepted_stamp;
        n_long_fired     = r_long_fired;
        n_click_tally    = r_click_tally;
        if (pressed && !r_button_held) begin
            if ((n_time_ms - r_accepted_stamp) > TIME_W'(r_debounce_lim)) begin
                n_button_held    = 1'b1;
                n_press_stamp    = n_time_ms;
                n_long_fired     = 1'b0;
                n_accepted_stamp = n_time_ms;
            end
        end else if (!pressed && r_button_held) begin
            n_button_held   = 1'b0;
            n_release_stamp = n_time_ms;
            if (!r_long_fired &&
                (n_time_ms - r_press_stamp) < TIME_W'(r_long_lim) &&
                r_click_tally != 2'd3) begin
                n_click_tally = r_click_tally + 2'd1;
            end
            n_long_fired = 1'b0;
        end

        event_v = EV_NONE;
        if (n_button_held && !n_long_fired &&
            (n_time_ms - n_press_stamp) > TIME_W'(r_long_lim)) begin
            n_long_fired = 1'b1;
            event_v      = EV_LONG;
        end
        if (n_click_tally != 2'd0 && !n_button_held &&
            (n_time_ms - n_release_stamp) > TIME_W'(r_quiet_lim)) begin
            event_v       = t_btn_event'({1'b0, n_click_tally});
            n_click_tally = 2'd0;
        end

        n_result.step         = step_v;
        n_result.position     = n_position;
        n_result.button_event = event_v;
        n_result.held_now     = n_button_held;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad_state     <= QUAD_DETENT;
            r_sub_count      <= 4'sd0;
            r_position       <= '0;
            r_time_ms        <= '0;
            r_press_stamp    <= '0;
            r_release_stamp  <= '0;
            r_accepted_stamp <= '0;
            r_button_held    <= 1'b0;
            r_long_fired     <= 1'b0;
            r_click_tally    <= 2'd0;
        end else if (in_fire) begin
            r_quad_state     <= n_quad_state;
            r_sub_count      <= n_sub_count;
            r_position       <= n_position;
            r_time_ms        <= n_time_ms;
            r_press_stamp    <= n_press_stamp;
            r_release_stamp  <= n_release_stamp;
            r_accepted_stamp <= n_accepted_stamp;
            r_button_held    <= n_button_held;
            r_long_fired     <= n_long_fired;
            r_click_tally    <= n_click_tally;
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_fire || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_v) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_result;
            end
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.step         = r_out.step;
    assign o_out.position     = r_out.position;
    assign o_out.button_event = r_out.button_event;
    assign o_out.held_now     = r_out.held_now;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid beat held without output beat");

    a_long_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_fired |-> r_button_held)
        else $error("long press flag set while released");

    a_long_event_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.button_event == EV_LONG) |-> o_out.held_now)
        else $error("long press beat without held button");

    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.button_event == EV_SINGLE ||
         o_out.button_event == EV_DOUBLE || o_out.button_event == EV_TRIPLE))
        |-> !o_out.held_now)
        else $error("click beat while button held");
`endif

endmodule
